>>> rtl/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg: shared types and constants for the postfix expression evaluator
// Character codes, status codes, transaction structs and sequencer states.
// ----------------------------------------------------------------------------
package pee_pkg;

	// operand and result width
	localparam int unsigned DATA_W = 32;

	// ascii codes that the evaluator recognizes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// result status, sticky error code
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_DIVZERO   = 3'd3,
		ST_INVALID   = 3'd4
	} status_t;

	// input transaction
	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} chr_item_t;

	// result transaction
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		status_t                  status;
	} res_item_t;

	// arithmetic unit operations
	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	// arithmetic unit control from the sequencer
	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctrl_t;

	// arithmetic unit states
	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_ABSA,
		A_ABSB,
		A_DIV,
		A_FIX,
		A_DONE
	} alu_state_t;

	// evaluator sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ_Y,
		S_READ_X,
		S_LOAD_X,
		S_CALC,
		S_FINISH,
		S_EMIT
	} seq_state_t;

endpackage

>>> rtl/pee_stack.sv
// ----------------------------------------------------------------------------
// pee_stack: operand stack storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module pee_stack #(
	parameter int unsigned DEPTH = 128,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [pee_pkg::DATA_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [pee_pkg::DATA_W-1:0]  rd_data
);
	import pee_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/pee_alu.sv
// ----------------------------------------------------------------------------
// pee_alu: iterative arithmetic unit
// One shared 33-bit adder does add, subtract, shift-add multiply, sign
// handling and restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pee_alu (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pee_pkg::alu_ctrl_t          ctrl,
	input  logic [pee_pkg::DATA_W-1:0]  x,
	input  logic [pee_pkg::DATA_W-1:0]  y,
	output logic                        done,
	output logic [pee_pkg::DATA_W-1:0]  result
);
	import pee_pkg::*;

	localparam int unsigned CntW = $clog2(DATA_W);

	alu_state_t        state_q, state_d;
	logic [DATA_W-1:0] acc_q, a_q, b_q;
	logic [CntW-1:0]   cnt_q;
	logic              neg_q;
	logic [DATA_W:0]   add_a, add_b, sum, rem_shift;
	logic              add_cin;
	logic              last_step;

	assign last_step = (cnt_q == CntW'(DATA_W - 1));
	assign rem_shift = {acc_q, a_q[DATA_W-1]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			A_IDLE: begin
				if (ctrl.start) begin
					unique case (ctrl.op)
						ALU_ADD, ALU_SUB: state_d = A_DONE;
						ALU_MUL:          state_d = A_MUL;
						ALU_DIV:          state_d = A_ABSA;
						default:          state_d = A_DONE;
					endcase
				end
			end
			A_MUL:   state_d = last_step ? A_DONE : A_MUL;
			A_ABSA:  state_d = A_ABSB;
			A_ABSB:  state_d = A_DIV;
			A_DIV:   state_d = last_step ? A_FIX : A_DIV;
			A_FIX:   state_d = A_DONE;
			A_DONE:  state_d = A_IDLE;
			default: state_d = A_IDLE;
		endcase
	end

	// shared adder operand selection
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_cin = 1'b0;
		unique case (state_q)
			A_IDLE: begin
				add_a = {1'b0, x};
				if (ctrl.op == ALU_SUB) begin
					add_b   = {1'b0, ~y};
					add_cin = 1'b1;
				end else begin
					add_b = {1'b0, y};
				end
			end
			A_MUL: begin
				add_a = {1'b0, acc_q};
				add_b = b_q[0] ? {1'b0, a_q} : '0;
			end
			A_ABSA, A_FIX: begin
				add_b   = {1'b0, ~a_q};
				add_cin = 1'b1;
			end
			A_ABSB: begin
				add_b   = {1'b0, ~b_q};
				add_cin = 1'b1;
			end
			A_DIV: begin
				add_a   = rem_shift;
				add_b   = {1'b1, ~b_q};
				add_cin = 1'b1;
			end
			default: begin
				add_a = '0;
			end
		endcase
	end

	assign sum    = add_a + add_b + {{DATA_W{1'b0}}, add_cin};
	assign done   = (state_q == A_DONE);
	assign result = acc_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				if (ctrl.start) begin
					a_q   <= x;
					b_q   <= y;
					cnt_q <= '0;
					neg_q <= x[DATA_W-1] ^ y[DATA_W-1];
					acc_q <= (ctrl.op == ALU_ADD || ctrl.op == ALU_SUB) ?
						sum[DATA_W-1:0] : '0;
				end
			end
			A_MUL: begin
				acc_q <= sum[DATA_W-1:0];
				a_q   <= {a_q[DATA_W-2:0], 1'b0};
				b_q   <= {1'b0, b_q[DATA_W-1:1]};
				cnt_q <= cnt_q + CntW'(1);
			end
			A_ABSA: begin
				if (a_q[DATA_W-1]) begin
					a_q <= sum[DATA_W-1:0];
				end
			end
			A_ABSB: begin
				if (b_q[DATA_W-1]) begin
					b_q <= sum[DATA_W-1:0];
				end
			end
			A_DIV: begin
				// restoring step: keep the difference when it is not negative
				if (!sum[DATA_W]) begin
					acc_q <= sum[DATA_W-1:0];
					a_q   <= {a_q[DATA_W-2:0], 1'b1};
				end else begin
					acc_q <= rem_shift[DATA_W-1:0];
					a_q   <= {a_q[DATA_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + CntW'(1);
			end
			A_FIX: begin
				acc_q <= neg_q ? sum[DATA_W-1:0] : a_q;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

>>> rtl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: single-digit postfix evaluator, 32-bit wrap
// Steps: a digit is decoded and finished; an operator reads y and x, loads
//   x and waits in calc on the one-bit-per-cycle shared arithmetic unit.
// A last character then reads the top and emits the result.
// One character in flight at a time; a finished result waits in an
//   output register while the next character is taken.
// Reset clears the stack count, the error and the result valid; no sweep.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
	parameter int unsigned STACK_DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                chr_valid,
	output logic                chr_stall,
	input  pee_pkg::chr_item_t  chr_item,
	output logic                res_valid,
	input  logic                res_stall,
	output pee_pkg::res_item_t  res_item
);
	import pee_pkg::*;

	localparam int unsigned AddrW = $clog2(STACK_DEPTH);
	localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

	seq_state_t        state_q, state_d;
	logic [7:0]        ch_q;
	logic              last_q;
	logic [CntW-1:0]   cnt_q, cnt_m1, cnt_m2;
	status_t           err_q, fin_status;
	logic [DATA_W-1:0] y_q;
	logic              res_valid_q;
	res_item_t         res_q;

	logic              is_digit, is_op, cnt_full, cnt_short, div_zero, out_free;
	alu_op_t           op;
	logic [DATA_W-1:0] digit_val;

	logic              wr_en, rd_en;
	logic [AddrW-1:0]  wr_addr, rd_addr;
	logic [DATA_W-1:0] wr_data, rd_data;

	alu_ctrl_t         alu_ctrl;
	logic              alu_done;
	logic [DATA_W-1:0] alu_result;

	// character decode and stack bookkeeping
	assign is_digit  = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
	assign is_op     = ch_q inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
	assign digit_val = DATA_W'(ch_q - CH_ZERO);
	assign cnt_full  = (cnt_q >= CntW'(STACK_DEPTH));
	assign cnt_short = (cnt_q < CntW'(2));
	assign cnt_m1    = cnt_q - CntW'(1);
	assign cnt_m2    = cnt_q - CntW'(2);
	assign div_zero  = (op == ALU_DIV) && (y_q == '0);
	assign out_free  = !res_valid_q || !res_stall;

	always_comb begin
		case (ch_q)
			CH_PLUS:  op = ALU_ADD;
			CH_MINUS: op = ALU_SUB;
			CH_STAR:  op = ALU_MUL;
			default:  op = ALU_DIV;
		endcase
	end

	// status of the finished expression
	always_comb begin
		if (err_q != ST_OK) begin
			fin_status = err_q;
		end else if (cnt_q == '0) begin
			fin_status = ST_UNDERFLOW;
		end else begin
			fin_status = ST_OK;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (chr_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (err_q != ST_OK || is_digit || cnt_short || !is_op) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_READ_Y;
				end
			end
			S_READ_Y: state_d = S_READ_X;
			S_READ_X: state_d = S_LOAD_X;
			S_LOAD_X: state_d = div_zero ? S_FINISH : S_CALC;
			S_CALC: begin
				if (alu_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: state_d = last_q ? S_EMIT : S_IDLE;
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		chr_stall      = (state_q != S_IDLE);
		wr_en          = 1'b0;
		wr_addr        = cnt_q[AddrW-1:0];
		wr_data        = digit_val;
		rd_en          = 1'b0;
		rd_addr        = cnt_m1[AddrW-1:0];
		alu_ctrl.start = 1'b0;
		alu_ctrl.op    = op;
		unique case (state_q)
			S_DECODE: begin
				wr_en = (err_q == ST_OK) && is_digit && !cnt_full;
			end
			S_READ_Y: begin
				rd_en = 1'b1;
			end
			S_READ_X: begin
				rd_en   = 1'b1;
				rd_addr = cnt_m2[AddrW-1:0];
			end
			S_LOAD_X: begin
				alu_ctrl.start = !div_zero;
			end
			S_CALC: begin
				wr_en   = alu_done;
				wr_addr = cnt_m2[AddrW-1:0];
				wr_data = alu_result;
			end
			S_FINISH: begin
				rd_en = last_q && (cnt_q != '0);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			err_q       <= ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_DECODE: begin
					if (err_q == ST_OK) begin
						if (is_digit) begin
							if (cnt_full) begin
								err_q <= ST_OVERFLOW;
							end else begin
								cnt_q <= cnt_q + CntW'(1);
							end
						end else if (cnt_short) begin
							err_q <= ST_UNDERFLOW;
						end else if (!is_op) begin
							err_q <= ST_INVALID;
						end
					end
				end
				S_LOAD_X: begin
					if (div_zero) begin
						err_q <= ST_DIVZERO;
					end
				end
				S_CALC: begin
					if (alu_done) begin
						cnt_q <= cnt_m1;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						cnt_q <= '0;
						err_q <= ST_OK;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
			// result handshake
			if (state_q == S_EMIT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && chr_valid) begin
			ch_q   <= chr_item.character;
			last_q <= chr_item.last;
		end
		if (state_q == S_READ_X) begin
			y_q <= rd_data;
		end
		if (state_q == S_EMIT && out_free) begin
			res_q.status <= fin_status;
			res_q.value  <= (fin_status == ST_OK) ? rd_data : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// operand stack
	pee_stack #(
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// shared arithmetic unit
	pee_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (alu_ctrl),
		.x     (rd_data),
		.y     (y_q),
		.done  (alu_done),
		.result(alu_result)
	);

	// arithmetic unit only finishes while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> (state_q == S_CALC))
		else $error("alu done outside calc state");

	// a push never goes past the stack depth
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q == S_DECODE) |-> (cnt_q < CntW'(STACK_DEPTH)))
		else $error("push onto full stack");

	// emitting a result leaves a clean stack and no error
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && $past(state_q) == S_EMIT) |->
			(cnt_q == '0 && err_q == ST_OK))
		else $error("stack or error not cleared after result");

endmodule
